@@ hdl/border_trim_bounding_box_unit_macros.svh @@
// assertion macros used by the border trim bounding box unit
`ifndef BORDER_TRIM_BOUNDING_BOX_UNIT_MACROS_SVH
`define BORDER_TRIM_BOUNDING_BOX_UNIT_MACROS_SVH

// same-cycle implication, inactive while in reset
`define BTB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("border trim check failed");

// next-cycle implication, inactive while in reset
`define BTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("border trim check failed");

`endif

@@ hdl/btb_pkg.sv @@
// types and constants of the border trim bounding box unit
`timescale 1ns / 1ps

package btb_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned CNT_W   = $clog2(MAX_DIM);
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam logic [DIM_W-1:0] FRAME_DIM_RESET     = DIM_W'(MAX_DIM);
  localparam logic [2:0]       CHANNEL_COUNT_RESET = 3'd4;
  localparam logic [7:0]       TOLERANCE_RESET     = 8'd20;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2,
    REG_TOLERANCE     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] chan_red;
    logic [7:0] chan_green;
    logic [7:0] chan_blue;
    logic [7:0] chan_alpha;
  } pixel_t;

  typedef struct packed {
    logic [CNT_W-1:0] crop_left;
    logic [CNT_W-1:0] crop_top;
    logic [DIM_W-1:0] crop_width;
    logic [DIM_W-1:0] crop_height;
    logic             found_content;
  } crop_t;

endpackage

@@ hdl/border_trim_bounding_box_unit.sv @@
// border trim bounding box unit: background match, box tracking and crop result
`timescale 1ns / 1ps

// Takes one frame in raster order, one pixel word per clock, and returns one crop
// word the cycle after the last pixel is taken. The first pixel of each frame
// is the background; the box covers every pixel that differs from it by more than
// the tolerance in any compared channel, or the whole frame with found_content low
// when none does. The pixel compare and box update keep pace with the input, so
// the sustained rate is one pixel per clock; in_ready drops only while a frame's
// last pixel waits on a crop word that has not been taken yet, as the single
// result register holds one word. Write the registers only between frames.
module border_trim_bounding_box_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  btb_pkg::pixel_t             in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output btb_pkg::crop_t              out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [btb_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [btb_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [btb_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import btb_pkg::*;

  `include "border_trim_bounding_box_unit_macros.svh"

  function automatic logic chan_differs(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] tol);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d > tol;
  endfunction

  // configuration registers
  logic [DIM_W-1:0] frame_width_r;
  logic [DIM_W-1:0] frame_height_r;
  logic [2:0]       channel_count_r;
  logic [7:0]       tolerance_r;

  // frame state
  logic [31:0]      bg_r;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] min_col_r, min_col_nxt;
  logic [CNT_W-1:0] max_col_r, max_col_nxt;
  logic [CNT_W-1:0] min_row_r, min_row_nxt;
  logic [CNT_W-1:0] max_row_r, max_row_nxt;
  logic             seen_r, seen_nxt;

  logic             out_valid_r, out_valid_nxt;
  crop_t            out_data_r, out_data_nxt;

  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic [DIM_W-1:0] w_m1, h_m1;
  logic             first_px, fg, col_last, row_last, is_last, in_fire;
  logic [DIM_W-1:0] box_w, box_h;
  logic [DIM_W:0]   right_edge;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= FRAME_DIM_RESET;
      frame_height_r  <= FRAME_DIM_RESET;
      channel_count_r <= CHANNEL_COUNT_RESET;
      tolerance_r     <= TOLERANCE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:   frame_width_r   <= cfg_pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT:  frame_height_r  <= cfg_pwdata[DIM_W-1:0];
        REG_CHANNEL_COUNT: channel_count_r <= cfg_pwdata[2:0];
        REG_TOLERANCE:     tolerance_r     <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:   cfg_prdata = DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT:  cfg_prdata = DATA_W'(frame_height_r);
      REG_CHANNEL_COUNT: cfg_prdata = DATA_W'(channel_count_r);
      REG_TOLERANCE:     cfg_prdata = DATA_W'(tolerance_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // saturate frame size to 1..MAX_DIM
  always_comb begin
    priority if (frame_width_r == '0)                  w_eff = DIM_W'(1);
    else if (frame_width_r > DIM_W'(MAX_DIM))          w_eff = DIM_W'(MAX_DIM);
    else                                               w_eff = frame_width_r;
    priority if (frame_height_r == '0)                 h_eff = DIM_W'(1);
    else if (frame_height_r > DIM_W'(MAX_DIM))         h_eff = DIM_W'(MAX_DIM);
    else                                               h_eff = frame_height_r;
  end

  assign w_m1     = w_eff - DIM_W'(1);
  assign h_m1     = h_eff - DIM_W'(1);
  assign col_last = {1'b0, col_r} >= w_m1;
  assign row_last = {1'b0, row_r} >= h_m1;
  assign is_last  = col_last && row_last;
  assign first_px = (col_r == '0) && (row_r == '0);

  // the frame's last pixel waits while the result register is still full
  assign in_ready = !is_last || !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // the first pixel matches itself, so it never counts as foreground
  assign fg = !first_px && (
      chan_differs(in_data.chan_red,   bg_r[7:0],   tolerance_r) ||
      chan_differs(in_data.chan_green, bg_r[15:8],  tolerance_r) ||
      chan_differs(in_data.chan_blue,  bg_r[23:16], tolerance_r) ||
      (channel_count_r[2] && chan_differs(in_data.chan_alpha, bg_r[31:24], tolerance_r)));

  always_comb begin
    min_col_nxt = min_col_r;
    max_col_nxt = max_col_r;
    min_row_nxt = min_row_r;
    max_row_nxt = max_row_r;
    seen_nxt    = seen_r;
    if (fg) begin
      if (!seen_r || col_r < min_col_r) min_col_nxt = col_r;
      if (!seen_r || col_r > max_col_r) max_col_nxt = col_r;
      if (!seen_r || row_r < min_row_r) min_row_nxt = row_r;
      if (!seen_r || row_r > max_row_r) max_row_nxt = row_r;
      seen_nxt = 1'b1;
    end
  end

  assign box_w = {1'b0, max_col_nxt} - {1'b0, min_col_nxt} + DIM_W'(1);
  assign box_h = {1'b0, max_row_nxt} - {1'b0, min_row_nxt} + DIM_W'(1);

  always_comb begin
    if (seen_nxt) begin
      out_data_nxt.crop_left     = min_col_nxt;
      out_data_nxt.crop_top      = min_row_nxt;
      out_data_nxt.crop_width    = box_w;
      out_data_nxt.crop_height   = box_h;
      out_data_nxt.found_content = 1'b1;
    end else begin
      out_data_nxt.crop_left     = '0;
      out_data_nxt.crop_top      = '0;
      out_data_nxt.crop_width    = w_eff;
      out_data_nxt.crop_height   = h_eff;
      out_data_nxt.found_content = 1'b0;
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (!col_last) begin
      col_nxt = col_r + CNT_W'(1);
    end else if (!row_last) begin
      col_nxt = '0;
      row_nxt = row_r + CNT_W'(1);
    end else begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire && is_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r        <= '0;
      col_r       <= '0;
      row_r       <= '0;
      min_col_r   <= '1;
      max_col_r   <= '0;
      min_row_r   <= '1;
      max_row_r   <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        if (first_px) begin
          bg_r <= {in_data.chan_alpha, in_data.chan_blue,
                   in_data.chan_green, in_data.chan_red};
        end
        col_r <= col_nxt;
        row_r <= row_nxt;
        if (is_last) begin
          min_col_r <= '1;
          max_col_r <= '0;
          min_row_r <= '1;
          max_row_r <= '0;
          seen_r    <= 1'b0;
        end else begin
          min_col_r <= min_col_nxt;
          max_col_r <= max_col_nxt;
          min_row_r <= min_row_nxt;
          max_row_r <= max_row_nxt;
          seen_r    <= seen_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_last) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign right_edge = {2'b00, out_data_r.crop_left} + {1'b0, out_data_r.crop_width};

  `BTB_ASSERT_NEXT(a_last_makes_word, clk, rst_n, in_fire && is_last, out_valid_r)
  `BTB_ASSERT_NEXT(a_frame_restart, clk, rst_n, in_fire && is_last,
    col_r == '0 && row_r == '0 && !seen_r)
  `BTB_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !in_ready,
    out_valid_r && !out_ready && is_last)
  `BTB_ASSERT_NOW(a_empty_box_origin, clk, rst_n, out_valid_r && !out_data_r.found_content,
    out_data_r.crop_left == '0 && out_data_r.crop_top == '0)
  `BTB_ASSERT_NOW(a_box_in_frame, clk, rst_n, out_valid_r && out_data_r.found_content,
    right_edge <= (DIM_W+1)'(MAX_DIM))

endmodule
